[rtl/core/ldc_pkg.sv]
// ldc_pkg: shared widths, fixed-point constants, fit tables and helpers for the
// LED dimming curve pipeline. No dependencies; imported by ldc_exp and the top level.
package ldc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PWM_PERIOD = 4096;

    localparam int IN_W   = 14;
    localparam int DUTY_W = 16;

    localparam logic [IN_W-1:0] IN_FULL = 14'd10000;

    // exponent log2(101) / 10000 in Q32, ln2 in Q32
    localparam logic [21:0] EXP_RATE  = 22'd2859680;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [33:0] ONE_Q32   = 34'h1_0000_0000;
    localparam int          EXP_TERMS = 13;

    localparam int REAL_W = FRAC_BITS + 7;
    typedef logic [REAL_W-1:0] lin_t;

    // voltage scaling: lin * gain / 100000
    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] BUCK_GAIN  = 15'd11355;
    localparam logic [GAIN_W-1:0] BOOST_GAIN = 15'd17064;
    localparam int PROD_W  = REAL_W + GAIN_W;
    localparam int V_DEN   = 100000;
    localparam int VQ_W    = PROD_W - 16;
    localparam int VREM_W  = 18;
    localparam int VPL_W   = 32 + VQ_W;
    localparam int VPH_W   = PROD_W - 32 + VQ_W;
    localparam int VSUM_W  = PROD_W + VQ_W;
    localparam logic [VQ_W-1:0] V_RECIP = VQ_W'(((64'd1 << PROD_W) - 64'd1) / V_DEN);

    localparam int VOLT_W = FRAC_BITS + 6;
    localparam int A_W    = FRAC_BITS + 7;
    localparam int COEF_W = 19;

    // fraction: a * coef / 1000000
    localparam int X_W     = A_W + COEF_W;
    localparam int Q_DEN   = 1000000;
    localparam int QQ_W    = X_W - 19;
    localparam int QREM_W  = 21;
    localparam int QPL_W   = 32 + QQ_W;
    localparam int QPH_W   = X_W - 32 + QQ_W;
    localparam int QSUM_W  = X_W + QQ_W;
    localparam logic [QQ_W-1:0] Q_RECIP = QQ_W'(((64'd1 << X_W) - 64'd1) / Q_DEN);

    localparam int DP_W = QQ_W + DUTY_W;
    localparam int DF_W = DP_W - FRAC_BITS;
    localparam logic [DF_W-1:0] BUCK_CAP  = DF_W'(PWM_PERIOD);
    localparam logic [DF_W-1:0] BOOST_CAP = DF_W'((576 * PWM_PERIOD) / 1000);

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH,
        SEG_TOP
    } seg_t;

    typedef struct packed {
        logic [VOLT_W-1:0] upper;
        logic [A_W-1:0]    offs;
        logic              neg;
        logic [COEF_W-1:0] coef;
    } fit_t;

    function automatic logic [63:0] milli_fix(input logic [63:0] milli);
        return (milli << FRAC_BITS) / 64'd1000;
    endfunction

    localparam logic [VOLT_W-1:0] BUCK_BASE  = VOLT_W'(milli_fix(64'd7845));
    localparam logic [VOLT_W-1:0] BOOST_BASE = VOLT_W'(milli_fix(64'd7936));

    localparam fit_t BUCK_FIT [4] = '{
        '{upper: VOLT_W'(milli_fix(64'd9275)),  offs: A_W'(milli_fix(64'd7664)),
          neg: 1'b1, coef: 19'd281970},
        '{upper: VOLT_W'(milli_fix(64'd13750)), offs: A_W'(milli_fix(64'd6959)),
          neg: 1'b0, coef: 19'd26520},
        '{upper: VOLT_W'(milli_fix(64'd16880)), offs: A_W'(milli_fix(64'd2529)),
          neg: 1'b1, coef: 19'd49485},
        '{upper: VOLT_W'(0),                    offs: A_W'(milli_fix(64'd26900)),
          neg: 1'b0, coef: 19'd21692}
    };

    localparam fit_t BOOST_FIT [4] = '{
        '{upper: VOLT_W'(milli_fix(64'd9122)),  offs: A_W'(milli_fix(64'd7900)),
          neg: 1'b1, coef: 19'd298954},
        '{upper: VOLT_W'(milli_fix(64'd14874)), offs: A_W'(milli_fix(64'd10369)),
          neg: 1'b0, coef: 19'd18742},
        '{upper: VOLT_W'(milli_fix(64'd20305)), offs: A_W'(milli_fix(64'd32852)),
          neg: 1'b0, coef: 19'd9913},
        '{upper: VOLT_W'(0),                    offs: A_W'(milli_fix(64'd86950)),
          neg: 1'b0, coef: 19'd4913}
    };

    function automatic fit_t fit_lookup(input logic buck, input seg_t seg);
        return buck ? BUCK_FIT[seg] : BOOST_FIT[seg];
    endfunction

endpackage

[rtl/core/led_dimming_curve_to_pwm_duty.sv]
// led_dimming_curve_to_pwm_duty: top level, perceived intensity to PWM compare level.
// Depends on ldc_pkg and ldc_exp.
//
// One request per cycle in, one duty level per cycle out while the output is not
// stalled. There are 40 stages in the exponential (two stages of exponent setup,
// a seed stage, three stages for each of the twelve Taylor terms after the first,
// and a shift stage), then 12 stages for voltage scaling, segment selection, the
// fit multiply, the divide by 10^6 and the period scaling. Every stage holds a
// valid bit and a stage takes new data whenever it is empty or its contents move
// on, so bubbles are squeezed out and intensity_ready stays high while the
// pipeline has room. The fit select buck_reg, set from cfg_data, resets to 1
// (buck fit); write it only while no request is in flight.
module led_dimming_curve_to_pwm_duty (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_data,
    input  logic                      intensity_valid,
    output logic                      intensity_ready,
    input  logic [ldc_pkg::IN_W-1:0]  intensity_centipercent,
    output logic                      duty_valid,
    input  logic                      duty_ready,
    output logic [ldc_pkg::DUTY_W-1:0] duty_level
);
    import ldc_pkg::*;

    localparam int NS = 12;

    typedef struct packed {
        logic live;
        seg_t seg;
    } tag_t;

    logic                buck_reg;
    logic                lin_valid;
    logic                lin_ready;
    lin_t                lin_value;
    logic [NS:1]         v_reg;
    logic [NS:1]         en;

    logic [PROD_W-1:0]   prod_reg;
    logic [VPL_W-1:0]    vpl_reg;
    logic [VPH_W-1:0]    vph_reg;
    logic [VREM_W-1:0]   vlo2_reg;
    logic [VQ_W-1:0]     vq_reg;
    logic [VREM_W-1:0]   vlo3_reg;
    logic [VQ_W-1:0]     vlin_reg;
    logic [VOLT_W-1:0]   volt_reg;
    logic [A_W-1:0]      a_reg;
    logic [X_W-1:0]      x_reg;
    logic [QPL_W-1:0]    qpl_reg;
    logic [QPH_W-1:0]    qph_reg;
    logic [QREM_W-1:0]   xlo8_reg;
    logic [QQ_W-1:0]     qq_reg;
    logic [QREM_W-1:0]   xlo9_reg;
    logic [QQ_W-1:0]     q_reg;
    logic [DF_W-1:0]     dfull_reg;
    logic [DUTY_W-1:0]   duty_reg;
    tag_t                tag5_reg;
    tag_t                tag6_reg;
    tag_t                tag7_reg;
    tag_t                tag8_reg;
    tag_t                tag9_reg;
    tag_t                tag10_reg;
    tag_t                tag11_reg;

    logic [GAIN_W-1:0]   gain;
    logic [PROD_W-1:0]   prod_next;
    logic [VPL_W-1:0]    vpl_next;
    logic [VPH_W-1:0]    vph_next;
    logic [VSUM_W-1:0]   vsum;
    logic [VQ_W-1:0]     vq_next;
    logic [VREM_W-1:0]   vrem;
    logic [VQ_W-1:0]     vlin_next;
    logic [VOLT_W-1:0]   volt_next;
    tag_t                tag5_next;
    fit_t                fit5_low;
    fit_t                fit5_mid;
    fit_t                fit5_high;
    fit_t                fit6;
    fit_t                fit7;
    logic [A_W-1:0]      volt_ext;
    logic [A_W-1:0]      a_next;
    logic [X_W-1:0]      x_next;
    logic [QPL_W-1:0]    qpl_next;
    logic [QPH_W-1:0]    qph_next;
    logic [QSUM_W-1:0]   qsum;
    logic [QQ_W-1:0]     qq_next;
    logic [QREM_W-1:0]   qrem;
    logic [QQ_W-1:0]     q_next;
    logic [DP_W-1:0]     dprod;
    logic [DF_W-1:0]     dfull_next;
    logic [DF_W-1:0]     cap;
    logic [DUTY_W-1:0]   duty_next;

    ldc_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_valid   (intensity_valid),
        .p_ready   (intensity_ready),
        .p_value   (intensity_centipercent),
        .lin_valid (lin_valid),
        .lin_ready (lin_ready),
        .lin_value (lin_value)
    );

    assign cfg_ready  = 1'b1;
    assign lin_ready  = en[1];
    assign duty_valid = v_reg[NS];
    assign duty_level = duty_reg;

    assign en[NS] = ~v_reg[NS] | duty_ready;
    for (genvar i = 1; i < NS; i++)
    begin : g_en
        assign en[i] = ~v_reg[i] | en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buck_reg <= 1'b1;
        else if (cfg_valid)
            buck_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1])
                v_reg[1] <= lin_valid;
            for (int i = 2; i <= NS; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_comb
    begin
        // voltage: lin * gain / 100000 + base
        gain      = buck_reg ? BUCK_GAIN : BOOST_GAIN;
        prod_next = PROD_W'(lin_value) * PROD_W'(gain);
        vpl_next  = VPL_W'(prod_reg[31:0]) * VPL_W'(V_RECIP);
        vph_next  = VPH_W'(prod_reg[PROD_W-1:32]) * VPH_W'(V_RECIP);
        vsum      = (VSUM_W'(vph_reg) << 32) + VSUM_W'(vpl_reg);
        vq_next   = vsum[PROD_W +: VQ_W];
        vrem      = vlo3_reg - VREM_W'(VREM_W'(vq_reg) * VREM_W'(V_DEN));
        vlin_next = vq_reg + VQ_W'(vrem >= VREM_W'(V_DEN));

        volt_next      = VOLT_W'(vlin_reg) + (buck_reg ? BUCK_BASE : BOOST_BASE);
        tag5_next.live = (vlin_reg != '0);
        fit5_low       = fit_lookup(buck_reg, SEG_LOW);
        fit5_mid       = fit_lookup(buck_reg, SEG_MID);
        fit5_high      = fit_lookup(buck_reg, SEG_HIGH);
        if (volt_next <= fit5_low.upper)
            tag5_next.seg = SEG_LOW;
        else if (volt_next <= fit5_mid.upper)
            tag5_next.seg = SEG_MID;
        else if (volt_next <= fit5_high.upper)
            tag5_next.seg = SEG_HIGH;
        else
            tag5_next.seg = SEG_TOP;

        // segment value, clamped at zero below a negative offset
        fit6     = fit_lookup(buck_reg, tag5_reg.seg);
        volt_ext = A_W'(volt_reg);
        if (fit6.neg)
            a_next = (volt_ext > fit6.offs) ? volt_ext - fit6.offs : '0;
        else
            a_next = volt_ext + fit6.offs;

        // fraction: a * coef / 1000000
        fit7     = fit_lookup(buck_reg, tag6_reg.seg);
        x_next   = X_W'(a_reg) * X_W'(fit7.coef);
        qpl_next = QPL_W'(x_reg[31:0]) * QPL_W'(Q_RECIP);
        qph_next = QPH_W'(x_reg[X_W-1:32]) * QPH_W'(Q_RECIP);
        qsum     = (QSUM_W'(qph_reg) << 32) + QSUM_W'(qpl_reg);
        qq_next  = qsum[X_W +: QQ_W];
        qrem     = xlo9_reg - QREM_W'(QREM_W'(qq_reg) * QREM_W'(Q_DEN));
        q_next   = qq_reg + QQ_W'(qrem >= QREM_W'(Q_DEN));

        dprod      = DP_W'(q_reg) * DP_W'(PWM_PERIOD);
        dfull_next = dprod[DP_W-1:FRAC_BITS];

        cap = buck_reg ? BUCK_CAP : BOOST_CAP;
        if (!tag11_reg.live)
            duty_next = '0;
        else if (tag11_reg.seg == SEG_TOP && dfull_reg > cap)
            duty_next = cap[DUTY_W-1:0];
        else
            duty_next = dfull_reg[DUTY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            prod_reg <= prod_next;
        if (en[2])
        begin
            vpl_reg  <= vpl_next;
            vph_reg  <= vph_next;
            vlo2_reg <= prod_reg[VREM_W-1:0];
        end
        if (en[3])
        begin
            vq_reg   <= vq_next;
            vlo3_reg <= vlo2_reg;
        end
        if (en[4])
            vlin_reg <= vlin_next;
        if (en[5])
        begin
            volt_reg <= volt_next;
            tag5_reg <= tag5_next;
        end
        if (en[6])
        begin
            a_reg    <= a_next;
            tag6_reg <= tag5_reg;
        end
        if (en[7])
        begin
            x_reg    <= x_next;
            tag7_reg <= tag6_reg;
        end
        if (en[8])
        begin
            qpl_reg  <= qpl_next;
            qph_reg  <= qph_next;
            xlo8_reg <= x_reg[QREM_W-1:0];
            tag8_reg <= tag7_reg;
        end
        if (en[9])
        begin
            qq_reg   <= qq_next;
            xlo9_reg <= xlo8_reg;
            tag9_reg <= tag8_reg;
        end
        if (en[10])
        begin
            q_reg     <= q_next;
            tag10_reg <= tag9_reg;
        end
        if (en[11])
        begin
            dfull_reg <= dfull_next;
            tag11_reg <= tag10_reg;
        end
        if (en[12])
            duty_reg <= duty_next;
    end

    a_room_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!duty_valid || duty_ready) |-> intensity_ready)
        else $error("pipeline has room but intensity_ready is low");

    a_duty_within_period: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid |-> (32'(duty_level) <= 32'(PWM_PERIOD)))
        else $error("duty level above the PWM period");

    a_boost_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_valid && !buck_reg) |-> (DF_W'(duty_level) <= BOOST_CAP))
        else $error("boost duty level above its cap");

endmodule

[rtl/core/ldc_exp.sv]
// ldc_exp: pipelined 101^(p/10000) - 1 in Q(FRAC_BITS), a Taylor series of 2^f
// with three stages per term. Depends on ldc_pkg.
module ldc_exp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    p_valid,
    output logic                    p_ready,
    input  logic [ldc_pkg::IN_W-1:0] p_value,
    output logic                    lin_valid,
    input  logic                    lin_ready,
    output ldc_pkg::lin_t           lin_value
);
    import ldc_pkg::*;

    localparam int GROUPS = EXP_TERMS - 1;

    typedef struct packed {
        logic [2:0]  n;
        logic [31:0] r;
        logic [33:0] sum;
        logic [31:0] x;
        logic [31:0] est;
    } lane_t;

    logic              e1_v_reg;
    logic              e2_v_reg;
    logic              fin_v_reg;
    logic              e1_en;
    logic              e2_en;
    logic              fin_en;
    logic [2:0]        e1_n_reg;
    logic [31:0]       e1_f_reg;
    logic [2:0]        e2_n_reg;
    logic [31:0]       e2_r_reg;
    lin_t              lin_reg;

    lane_t             c_reg [0:GROUPS];
    lane_t             a_reg [1:GROUPS];
    lane_t             b_reg [1:GROUPS];
    logic              c_v_reg [0:GROUPS];
    logic              a_v_reg [1:GROUPS];
    logic              b_v_reg [1:GROUPS];
    logic [GROUPS:0]   c_en;
    logic [GROUPS:1]   a_en;
    logic [GROUPS:1]   b_en;

    logic [IN_W-1:0]   p_sat;
    logic [34:0]       t_next;
    logic [63:0]       rp;
    lane_t             c0_next;
    logic [39:0]       shifted;
    logic [39:0]       diff;
    lin_t              lin_next;

    assign fin_en         = ~fin_v_reg | lin_ready;
    assign c_en[GROUPS]   = ~c_v_reg[GROUPS] | fin_en;
    assign e2_en          = ~e2_v_reg | c_en[0];
    assign e1_en          = ~e1_v_reg | e2_en;
    assign p_ready        = e1_en;
    assign lin_valid      = fin_v_reg;
    assign lin_value      = lin_reg;

    always_comb
    begin
        p_sat       = (p_value > IN_FULL) ? IN_FULL : p_value;
        t_next      = 35'(p_sat) * 35'(EXP_RATE);
        rp          = 64'(e1_f_reg) * 64'(LN2_Q32);
        c0_next.n   = e2_n_reg;
        c0_next.r   = e2_r_reg;
        c0_next.x   = e2_r_reg;
        c0_next.sum = ONE_Q32 + 34'(e2_r_reg);
        c0_next.est = '0;
        shifted     = 40'(c_reg[GROUPS].sum) << c_reg[GROUPS].n;
        diff        = shifted - 40'(ONE_Q32);
        lin_next    = diff[32-FRAC_BITS +: REAL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg   <= 1'b0;
            e2_v_reg   <= 1'b0;
            c_v_reg[0] <= 1'b0;
            fin_v_reg  <= 1'b0;
        end
        else
        begin
            if (e1_en)
                e1_v_reg <= p_valid;
            if (e2_en)
                e2_v_reg <= e1_v_reg;
            if (c_en[0])
                c_v_reg[0] <= e2_v_reg;
            if (fin_en)
                fin_v_reg <= c_v_reg[GROUPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (e1_en)
        begin
            e1_n_reg <= t_next[34:32];
            e1_f_reg <= t_next[31:0];
        end
        if (e2_en)
        begin
            e2_n_reg <= e1_n_reg;
            e2_r_reg <= rp[63:32];
        end
        if (c_en[0])
            c_reg[0] <= c0_next;
        if (fin_en)
            lin_reg <= lin_next;
    end

    // term k = ((term * r) >> 32) / k, divide by reciprocal with one correction
    for (genvar g = 1; g <= GROUPS; g++)
    begin : g_term
        localparam logic [7:0]  K     = 8'(g + 1);
        localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / (g + 1));

        logic [63:0] hp;
        logic [63:0] ep;
        logic [7:0]  rem;
        logic [31:0] term;
        lane_t       a_next;
        lane_t       b_next;
        lane_t       c_next;

        assign b_en[g]   = ~b_v_reg[g] | c_en[g];
        assign a_en[g]   = ~a_v_reg[g] | b_en[g];
        assign c_en[g-1] = ~c_v_reg[g-1] | a_en[g];

        always_comb
        begin
            hp          = 64'(c_reg[g-1].x) * 64'(c_reg[g-1].r);
            a_next      = c_reg[g-1];
            a_next.x    = hp[63:32];
            ep          = 64'(a_reg[g].x) * 64'(RECIP);
            b_next      = a_reg[g];
            b_next.est  = ep[63:32];
            rem         = b_reg[g].x[7:0] - 8'(b_reg[g].est[7:0] * K);
            term        = b_reg[g].est + 32'(rem >= K);
            c_next      = b_reg[g];
            c_next.x    = term;
            c_next.sum  = b_reg[g].sum + 34'(term);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[g] <= 1'b0;
                b_v_reg[g] <= 1'b0;
                c_v_reg[g] <= 1'b0;
            end
            else
            begin
                if (a_en[g])
                    a_v_reg[g] <= c_v_reg[g-1];
                if (b_en[g])
                    b_v_reg[g] <= a_v_reg[g];
                if (c_en[g])
                    c_v_reg[g] <= b_v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (a_en[g])
                a_reg[g] <= a_next;
            if (b_en[g])
                b_reg[g] <= b_next;
            if (c_en[g])
                c_reg[g] <= c_next;
        end
    end

endmodule

[tb/ldc_duty_checker.sv]
// ldc_duty_checker: watches the config, intensity and duty channels of
// led_dimming_curve_to_pwm_duty, predicts each duty level and compares in order.
// Depends on ldc_pkg for port widths and segment names.
`timescale 1ns / 1ps

module ldc_duty_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_data,
    input  logic                       intensity_valid,
    input  logic                       intensity_ready,
    input  logic [ldc_pkg::IN_W-1:0]   intensity_centipercent,
    input  logic                       duty_valid,
    input  logic                       duty_ready,
    input  logic [ldc_pkg::DUTY_W-1:0] duty_level,
    output int                         errors,
    output int                         outstanding
);
    import ldc_pkg::*;

    typedef struct {
        logic [63:0] upper_milli;
        logic [63:0] offs_milli;
        bit          subtract;
        logic [63:0] coef_micro;
    } fit_piece_t;

    logic              fit_is_buck = 1'b1;
    logic [DUTY_W-1:0] expected_duty [$];
    logic [DUTY_W-1:0] want;

    function automatic logic [63:0] fix_from_milli(input logic [63:0] milli);
        return (milli << FRAC_BITS) / 64'd1000;
    endfunction

    function automatic fit_piece_t fit_piece(input logic buck, input seg_t seg);
        fit_piece_t fp;
        if (buck)
        begin
            case (seg)
                SEG_LOW:  fp = '{64'd9275,  64'd7664,  1'b1, 64'd281970};
                SEG_MID:  fp = '{64'd13750, 64'd6959,  1'b0, 64'd26520};
                SEG_HIGH: fp = '{64'd16880, 64'd2529,  1'b1, 64'd49485};
                default:  fp = '{64'd0,     64'd26900, 1'b0, 64'd21692};
            endcase
        end
        else
        begin
            case (seg)
                SEG_LOW:  fp = '{64'd9122,  64'd7900,  1'b1, 64'd298954};
                SEG_MID:  fp = '{64'd14874, 64'd10369, 1'b0, 64'd18742};
                SEG_HIGH: fp = '{64'd20305, 64'd32852, 1'b0, 64'd9913};
                default:  fp = '{64'd0,     64'd86950, 1'b0, 64'd4913};
            endcase
        end
        return fp;
    endfunction

    // 101^(p/10000) - 1 in Q(FRAC_BITS); 2^f via Taylor series of e^(f*ln2)
    function automatic logic [63:0] linear_from_perceived(input logic [63:0] p);
        logic [63:0] t, n, f, r, term, sum, k;
        t = p * 64'd2859680;
        n = t >> 32;
        f = t & 64'hFFFF_FFFF;
        r = (f * 64'd2977044472) >> 32;
        term = 64'd1 << 32;
        sum = term;
        for (k = 64'd1; k <= 64'd13; k++)
        begin
            term = ((term * r) >> 32) / k;
            sum = sum + term;
        end
        if (n > 64'd7)
            n = 64'd7;
        sum = sum << n;
        return (sum - (64'd1 << 32)) >> (32 - FRAC_BITS);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for_intensity(input logic [IN_W-1:0] level,
                                                             input logic buck);
        logic [63:0] p, base, gain, cap, volt, a, q, duty;
        seg_t        seg;
        fit_piece_t  fp;
        p = 64'(level);
        if (p > 64'd10000)
            p = 64'd10000;
        base = fix_from_milli(buck ? 64'd7845 : 64'd7936);
        gain = buck ? 64'd11355 : 64'd17064;
        cap = buck ? 64'(PWM_PERIOD) : 64'((576 * PWM_PERIOD) / 1000);
        volt = linear_from_perceived(p) * gain / 64'd100000 + base;
        duty = 64'd0;
        if (volt > base)
        begin
            seg = SEG_LOW;
            fp = fit_piece(buck, seg);
            while (seg != SEG_TOP && volt > fix_from_milli(fp.upper_milli))
            begin
                seg = seg_t'(seg + 1);
                fp = fit_piece(buck, seg);
            end
            a = fix_from_milli(fp.offs_milli);
            if (fp.subtract)
                a = (volt > a) ? volt - a : 64'd0;
            else
                a = volt + a;
            q = a * fp.coef_micro / 64'd1000000;
            duty = (q * 64'(PWM_PERIOD)) >> FRAC_BITS;
            if (seg == SEG_TOP && duty > cap)
                duty = cap;
        end
        return duty[DUTY_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_is_buck = 1'b1;
            expected_duty.delete();
        end
        else
        begin
            if (duty_valid && duty_ready)
            begin
                if (expected_duty.size() == 0)
                begin
                    $error("duty_level: no request pending, actual %0d", duty_level);
                    errors++;
                end
                else
                begin
                    want = expected_duty.pop_front();
                    if (duty_level !== want)
                    begin
                        $error("duty_level: expected %0d actual %0d", want, duty_level);
                        errors++;
                    end
                end
            end
            if (intensity_valid && intensity_ready)
                expected_duty.push_back(duty_for_intensity(intensity_centipercent, fit_is_buck));
            if (cfg_valid && cfg_ready)
                fit_is_buck = cfg_data;
        end
        outstanding = expected_duty.size();
    end

endmodule

[tb/tb_led_dimming_curve_to_pwm_duty.sv]
// tb_led_dimming_curve_to_pwm_duty: drives intensity requests, fit selection and
// output stalls, and reports the verdict. Depends on ldc_pkg, the DUT and ldc_duty_checker.
`timescale 1ns / 1ps

module tb_led_dimming_curve_to_pwm_duty;

    import ldc_pkg::*;

    localparam logic FIT_BUCK  = 1'b1;
    localparam logic FIT_BOOST = 1'b0;
    localparam int   PHASE_ITEMS = 185;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_CYCLES = 64;
    localparam int   CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              intensity_valid;
    logic              intensity_ready;
    logic [IN_W-1:0]   intensity_centipercent;
    logic              duty_valid;
    logic              duty_ready;
    logic [DUTY_W-1:0] duty_level;

    int check_errors;
    int check_pending;
    int stall_pct = 0;
    int hold_requests = 0;
    int cycle_count = 0;

    logic [IN_W-1:0] corner_points [12] = '{
        14'd0, 14'd1, 14'd100, 14'd1500, 14'd3000, 14'd5000, 14'd5461,
        14'd9000, 14'd9999, 14'd10000, 14'd10922, 14'd16383
    };

    led_dimming_curve_to_pwm_duty u_top (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_data               (cfg_data),
        .intensity_valid        (intensity_valid),
        .intensity_ready        (intensity_ready),
        .intensity_centipercent (intensity_centipercent),
        .duty_valid             (duty_valid),
        .duty_ready             (duty_ready),
        .duty_level             (duty_level)
    );

    ldc_duty_checker u_checker (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_data               (cfg_data),
        .intensity_valid        (intensity_valid),
        .intensity_ready        (intensity_ready),
        .intensity_centipercent (intensity_centipercent),
        .duty_valid             (duty_valid),
        .duty_ready             (duty_ready),
        .duty_level             (duty_level),
        .errors                 (check_errors),
        .outstanding            (check_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // output side: random stalls, plus a long hold-off on request
    initial
    begin : duty_sink
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        duty_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                duty_ready <= 1'b0;
                hold_left--;
            end
            else
                duty_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("led_dimming_curve_to_pwm_duty regression: fail");
        $finish;
    end

    function automatic logic [IN_W-1:0] random_intensity();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return IN_W'($urandom_range(16383, 10001));
        else if (pick < 18)
            return IN_W'($urandom_range(300));
        else
            return IN_W'($urandom_range(10000));
    endfunction

    task automatic offer_intensity(input logic [IN_W-1:0] level, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            intensity_valid <= 1'b0;
            @(negedge clk);
        end
        intensity_valid <= 1'b1;
        intensity_centipercent <= level;
        do @(posedge clk); while (!intensity_ready);
        @(negedge clk);
    endtask

    // fit select only changes with the pipeline empty
    task automatic write_fit(input logic fit);
        intensity_valid <= 1'b0;
        while (check_pending != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= fit;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int idle_pct;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        intensity_valid = 1'b0;
        intensity_centipercent = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners on the reset fit, then on boost
        foreach (corner_points[i])
            offer_intensity(corner_points[i], 0);
        write_fit(FIT_BOOST);
        foreach (corner_points[i])
            offer_intensity(corner_points[i], 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_fit((phase % 2 == 0) ? FIT_BUCK : FIT_BOOST);
            case (phase)
                0:       begin idle_pct = 0;  stall_pct <= 0;  end
                1:       begin idle_pct = 56; stall_pct <= 0;  end
                2:       begin idle_pct = 0;  stall_pct <= 56; end
                default: begin idle_pct = 22; stall_pct <= 22; end
            endcase
            if (phase == 0)
                hold_requests <= hold_requests + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_intensity(random_intensity(), idle_pct);
        end

        intensity_valid <= 1'b0;
        while (check_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (check_errors == 0)
            $display("led_dimming_curve_to_pwm_duty regression: pass");
        else
            $display("led_dimming_curve_to_pwm_duty regression: fail");
        $finish;
    end

endmodule
